// ===== rtl/vehicle_mode_supervisor_defines.svh =====
// Assertion macros shared by the vehicle mode supervisor RTL.
`ifndef VEHICLE_MODE_SUPERVISOR_DEFINES_SVH
`define VEHICLE_MODE_SUPERVISOR_DEFINES_SVH

// Same-cycle implication, switched off while reset is high.
`define VMS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vehicle_mode_supervisor: same-cycle check failed");

// Next-cycle implication, switched off while reset is high.
`define VMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vehicle_mode_supervisor: next-cycle check failed");

`endif

// ===== rtl/vms_pkg.sv =====
// Types, constants and helpers shared by the vehicle mode supervisor.
package vms_pkg;

  localparam int TIME_BITS_DEFAULT = 32;
  localparam int NOW_BITS          = 32;
  localparam int TIMEOUT_BITS      = 16;
  localparam int CFG_INDEX_BITS    = 2;
  localparam int CFG_DATA_BITS     = 16;

  localparam logic [CFG_INDEX_BITS-1:0] REG_HEARTBEAT_TIMEOUT = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ARMING_TIMEOUT    = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ESCALATE          = 2'd2;

  localparam logic [TIMEOUT_BITS-1:0] HEARTBEAT_TIMEOUT_RESET = 16'd200;
  localparam logic [TIMEOUT_BITS-1:0] ARMING_TIMEOUT_RESET    = 16'd5000;

  // Output codes of the mode field.
  localparam logic [2:0] CODE_INIT   = 3'd0;
  localparam logic [2:0] CODE_MANUAL = 3'd1;
  localparam logic [2:0] CODE_ARMING = 3'd2;
  localparam logic [2:0] CODE_AUTO   = 3'd3;
  localparam logic [2:0] CODE_ESTOP  = 3'd4;

  typedef enum logic [2:0] {
    KIND_HEARTBEAT   = 3'd0,
    KIND_OVERRIDE    = 3'd1,
    KIND_STATUS_TICK = 3'd2,
    KIND_REQ_MANUAL  = 3'd3,
    KIND_REQ_AUTO    = 3'd4,
    KIND_REQ_ESTOP   = 3'd5,
    KIND_CLEAR_ESTOP = 3'd6,
    KIND_READY       = 3'd7
  } kind_t;

  typedef enum logic [4:0] {
    ST_INIT   = 5'b00001,
    ST_MANUAL = 5'b00010,
    ST_ARMING = 5'b00100,
    ST_AUTO   = 5'b01000,
    ST_ESTOP  = 5'b10000
  } mode_t;

  typedef struct packed {
    kind_t                kind;
    logic [NOW_BITS-1:0]  now_ms;
  } vms_in_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       success;
    logic       estop_latched;
    logic       start_autopilot;
    logic       stop_autopilot;
  } vms_out_t;

  typedef struct packed {
    logic [TIMEOUT_BITS-1:0] heartbeat_timeout_ms;
    logic [TIMEOUT_BITS-1:0] arming_timeout_ms;
    logic                    escalate_to_estop;
  } vms_cfg_t;

  typedef struct packed {
    mode_t mode;
    logic  latch;
  } vms_ctrl_t;

  function automatic logic [2:0] mode_code(mode_t m);
    logic [2:0] code;
    unique case (m)
      ST_INIT:   code = CODE_INIT;
      ST_MANUAL: code = CODE_MANUAL;
      ST_ARMING: code = CODE_ARMING;
      ST_AUTO:   code = CODE_AUTO;
      ST_ESTOP:  code = CODE_ESTOP;
      default:   code = CODE_INIT;
    endcase
    return code;
  endfunction

endpackage

// ===== rtl/vms_step.sv =====
// Transition logic: next supervisor state and result for one event.
module vms_step #(
  parameter int TIME_BITS = vms_pkg::TIME_BITS_DEFAULT
) (
  input  vms_pkg::vms_ctrl_t   ctrl,
  input  logic [TIME_BITS-1:0] arming_start,
  input  logic [TIME_BITS-1:0] last_heartbeat,
  input  vms_pkg::vms_cfg_t    cfg,
  input  vms_pkg::vms_in_t     item,
  output vms_pkg::vms_ctrl_t   ctrl_next,
  output logic [TIME_BITS-1:0] arming_start_next,
  output logic [TIME_BITS-1:0] last_heartbeat_next,
  output vms_pkg::vms_out_t    result
);

  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] arming_elapsed;
  logic [TIME_BITS-1:0] heartbeat_elapsed;
  logic                 arming_expired;
  logic                 heartbeat_stale;
  logic                 want;
  vms_pkg::mode_t       target;
  logic                 latch_pre;
  logic                 latch_set;
  logic                 differs;
  logic                 blocked;
  logic                 ok;
  logic                 pulse_start;
  logic                 pulse_stop;

  assign now               = TIME_BITS'(item.now_ms);
  assign arming_elapsed    = now - arming_start;
  assign heartbeat_elapsed = now - last_heartbeat;
  assign arming_expired    = arming_elapsed > TIME_BITS'(cfg.arming_timeout_ms);
  assign heartbeat_stale   = heartbeat_elapsed > TIME_BITS'(cfg.heartbeat_timeout_ms);

  always_comb begin
    want                = 1'b0;
    target              = ctrl.mode;
    latch_pre           = ctrl.latch;
    ok                  = 1'b0;
    pulse_start         = 1'b0;
    pulse_stop          = 1'b0;
    ctrl_next           = ctrl;
    arming_start_next   = arming_start;
    last_heartbeat_next = last_heartbeat;

    // Work out whether the event asks for a move, and to where.
    unique case (item.kind)
      vms_pkg::KIND_HEARTBEAT: begin
        last_heartbeat_next = now;
      end
      vms_pkg::KIND_OVERRIDE: begin
        want   = (ctrl.mode == vms_pkg::ST_AUTO);
        target = vms_pkg::ST_MANUAL;
      end
      vms_pkg::KIND_STATUS_TICK: begin
        if (ctrl.mode == vms_pkg::ST_INIT) begin
          want   = 1'b1;
          target = vms_pkg::ST_MANUAL;
        end else if (ctrl.mode == vms_pkg::ST_ARMING) begin
          want   = arming_expired;
          target = vms_pkg::ST_MANUAL;
        end else if (ctrl.mode == vms_pkg::ST_AUTO) begin
          want   = heartbeat_stale;
          target = cfg.escalate_to_estop ? vms_pkg::ST_ESTOP : vms_pkg::ST_MANUAL;
        end
      end
      vms_pkg::KIND_REQ_MANUAL: begin
        want   = 1'b1;
        target = vms_pkg::ST_MANUAL;
      end
      vms_pkg::KIND_REQ_AUTO: begin
        want   = !ctrl.latch;
        target = vms_pkg::ST_ARMING;
      end
      vms_pkg::KIND_REQ_ESTOP: begin
        want   = 1'b1;
        target = vms_pkg::ST_ESTOP;
      end
      vms_pkg::KIND_CLEAR_ESTOP: begin
        // The latch is cleared whether or not the move succeeds.
        latch_pre = 1'b0;
        want      = 1'b1;
        target    = vms_pkg::ST_MANUAL;
      end
      vms_pkg::KIND_READY: begin
        want   = !ctrl.latch && (ctrl.mode == vms_pkg::ST_ARMING);
        target = vms_pkg::ST_AUTO;
      end
      default: begin
        want = 1'b0;
      end
    endcase

    // Shared transition rule.
    differs   = want && (target != ctrl.mode);
    latch_set = latch_pre | (differs && (target == vms_pkg::ST_ESTOP));
    blocked   = latch_set && (target != vms_pkg::ST_ESTOP)
                && (target != vms_pkg::ST_MANUAL);
    ctrl_next.latch = latch_set;

    if (differs && !blocked) begin
      ok = 1'b1;
      if (target == vms_pkg::ST_ARMING) begin
        arming_start_next = now;
        pulse_start       = 1'b1;
      end
      if (target == vms_pkg::ST_AUTO) begin
        last_heartbeat_next = now;
      end else if (ctrl.mode == vms_pkg::ST_AUTO) begin
        last_heartbeat_next = '0;
        pulse_stop          = 1'b1;
      end
      ctrl_next.mode = target;
    end

    result.mode            = vms_pkg::mode_code(ctrl_next.mode);
    result.success         = ok;
    result.estop_latched   = ctrl_next.latch;
    result.start_autopilot = pulse_start;
    result.stop_autopilot  = pulse_stop;
  end

endmodule

// ===== rtl/vehicle_mode_supervisor.sv =====
// Vehicle mode supervisor top level: state, configuration and output buffering.
// Each result is registered in the output buffer. Throughput: one event per cycle
// while the skid register is empty; a two-entry output buffer keeps input ready
// while one result waits, so the state update and compare path sets the rate.
// Reset (rst, synchronous, active high): mode init, latch clear, time stamps 0,
// timeouts 200 ms and 5000 ms, escalation off, output buffer empty.
`include "vehicle_mode_supervisor_defines.svh"

module vehicle_mode_supervisor #(
  parameter int TIME_BITS = vms_pkg::TIME_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  vms_pkg::vms_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output vms_pkg::vms_out_t                   out_data,
  input  logic                                cfg_we,
  input  logic [vms_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [vms_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  // Supervisor state.
  vms_pkg::vms_ctrl_t   ctrl;
  vms_pkg::vms_ctrl_t   ctrl_next;
  logic [TIME_BITS-1:0] arming_start;
  logic [TIME_BITS-1:0] arming_start_next;
  logic [TIME_BITS-1:0] last_heartbeat;
  logic [TIME_BITS-1:0] last_heartbeat_next;
  vms_pkg::vms_cfg_t    cfg;

  // Output buffer: the main register drives the port, the skid register
  // catches a result produced while the main one is stalled.
  vms_pkg::vms_out_t    result;
  vms_pkg::vms_out_t    skid_data;
  logic                 skid_valid;
  logic                 in_xfer;
  logic                 out_xfer;

  // Terms used by the checks at the end of the module.
  logic                 start_seen;
  logic                 start_legal;
  logic                 latch_legal;

  assign in_ready = !skid_valid;
  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  vms_step #(
    .TIME_BITS (TIME_BITS)
  ) u_step (
    .ctrl                (ctrl),
    .arming_start        (arming_start),
    .last_heartbeat      (last_heartbeat),
    .cfg                 (cfg),
    .item                (in_data),
    .ctrl_next           (ctrl_next),
    .arming_start_next   (arming_start_next),
    .last_heartbeat_next (last_heartbeat_next),
    .result              (result)
  );

  // Configuration writes; an index past the last register is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.heartbeat_timeout_ms <= vms_pkg::HEARTBEAT_TIMEOUT_RESET;
      cfg.arming_timeout_ms    <= vms_pkg::ARMING_TIMEOUT_RESET;
      cfg.escalate_to_estop    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vms_pkg::REG_HEARTBEAT_TIMEOUT: cfg.heartbeat_timeout_ms <= cfg_data;
        vms_pkg::REG_ARMING_TIMEOUT:    cfg.arming_timeout_ms    <= cfg_data;
        vms_pkg::REG_ESCALATE:          cfg.escalate_to_estop    <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // The state moves on at every event transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.mode      <= vms_pkg::ST_INIT;
      ctrl.latch     <= 1'b0;
      arming_start   <= '0;
      last_heartbeat <= '0;
    end else if (in_xfer) begin
      ctrl           <= ctrl_next;
      arming_start   <= arming_start_next;
      last_heartbeat <= last_heartbeat_next;
    end
  end

  // Output buffer control. A new result goes to the main register when that
  // register is empty or being drained this cycle, otherwise to the skid
  // register. A waiting skid entry moves up when the main one is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (out_xfer) begin
          skid_valid <= 1'b0;
        end
      end else if (in_xfer) begin
        if (out_valid && !out_ready) begin
          skid_valid <= 1'b1;
        end else begin
          out_valid <= 1'b1;
        end
      end else if (out_xfer) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_xfer) begin
        out_data <= skid_data;
      end
    end else if (in_xfer) begin
      if (out_valid && !out_ready) begin
        skid_data <= result;
      end else begin
        out_data <= result;
      end
    end
  end

  assign start_seen  = out_valid && out_data.start_autopilot;
  assign start_legal = out_data.success && (out_data.mode == vms_pkg::CODE_ARMING);
  assign latch_legal = (ctrl.mode == vms_pkg::ST_ESTOP) || (ctrl.mode == vms_pkg::ST_MANUAL);

  // A start request is only ever raised together with a successful move into arming.
  `VMS_ASSERT_IMPLY(a_start_means_arming, clk, rst, start_seen, start_legal)

  // While the emergency stop latch is set the block sits in estop or manual.
  `VMS_ASSERT_IMPLY(a_latch_mode, clk, rst, ctrl.latch, latch_legal)

  // The skid register never holds a result ahead of the main register.
  `VMS_ASSERT_IMPLY(a_skid_behind_main, clk, rst, skid_valid, out_valid)

  // An event taken into an empty buffer lands in the main register.
  `VMS_ASSERT_NEXT(a_empty_fill, clk, rst, in_xfer && !out_valid, out_valid && !skid_valid)

endmodule

// ===== sim/vms_checker.sv =====
`timescale 1ns / 100ps
// Checker for the vehicle mode supervisor: predicts every result and compares it.
module vms_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  vms_pkg::vms_in_t                    in_data,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  vms_pkg::vms_out_t                   out_data,
  input  logic                                cfg_we,
  input  logic [vms_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [vms_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output int                                  mismatches,
  output int                                  awaited
);
  import vms_pkg::*;

  logic [2:0]  cur_mode;
  logic        latched;
  logic [31:0] arm_stamp;
  logic [31:0] beat_stamp;
  logic [15:0] beat_limit;
  logic [15:0] arm_limit;
  logic        escalate;
  logic        fire_start;
  logic        fire_stop;

  vms_out_t    expected_q[$];

  // Shared rule for every requested mode change.
  function automatic logic change_mode(logic [2:0] target, logic [31:0] now);
    if (cur_mode == target) return 1'b0;
    if (target == CODE_ESTOP) latched = 1'b1;
    if (latched && target != CODE_ESTOP && target != CODE_MANUAL) return 1'b0;
    if (target == CODE_ARMING) begin
      arm_stamp  = now;
      fire_start = 1'b1;
    end
    if (target == CODE_AUTO) begin
      beat_stamp = now;
    end else if (cur_mode == CODE_AUTO) begin
      beat_stamp = '0;
      fire_stop  = 1'b1;
    end
    cur_mode = target;
    return 1'b1;
  endfunction

  function automatic vms_out_t predict_event(vms_in_t ev);
    logic     ok;
    vms_out_t res;
    ok         = 1'b0;
    fire_start = 1'b0;
    fire_stop  = 1'b0;
    case (ev.kind)
      KIND_HEARTBEAT: beat_stamp = ev.now_ms;
      KIND_OVERRIDE: begin
        if (cur_mode == CODE_AUTO) ok = change_mode(CODE_MANUAL, ev.now_ms);
      end
      KIND_STATUS_TICK: begin
        if (cur_mode == CODE_INIT) begin
          ok = change_mode(CODE_MANUAL, ev.now_ms);
        end else if (cur_mode == CODE_ARMING) begin
          if (ev.now_ms - arm_stamp > {16'd0, arm_limit})
            ok = change_mode(CODE_MANUAL, ev.now_ms);
        end else if (cur_mode == CODE_AUTO) begin
          if (ev.now_ms - beat_stamp > {16'd0, beat_limit})
            ok = change_mode(escalate ? CODE_ESTOP : CODE_MANUAL, ev.now_ms);
        end
      end
      KIND_REQ_MANUAL: ok = change_mode(CODE_MANUAL, ev.now_ms);
      KIND_REQ_AUTO: begin
        if (!latched) ok = change_mode(CODE_ARMING, ev.now_ms);
      end
      KIND_REQ_ESTOP: ok = change_mode(CODE_ESTOP, ev.now_ms);
      KIND_CLEAR_ESTOP: begin
        latched = 1'b0;
        ok      = change_mode(CODE_MANUAL, ev.now_ms);
      end
      default: begin
        if (!latched && cur_mode == CODE_ARMING) ok = change_mode(CODE_AUTO, ev.now_ms);
      end
    endcase
    res.mode            = cur_mode;
    res.success         = ok;
    res.estop_latched   = latched;
    res.start_autopilot = fire_start;
    res.stop_autopilot  = fire_stop;
    return res;
  endfunction

  task automatic check_field(string field, logic [2:0] want, logic [2:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  // Results are checked before the new event is predicted: a result never
  // leaves in the same cycle as the event that caused it.
  always @(posedge clk) begin : monitor
    vms_out_t want;
    if (rst) begin
      cur_mode   = CODE_INIT;
      latched    = 1'b0;
      arm_stamp  = '0;
      beat_stamp = '0;
      beat_limit = HEARTBEAT_TIMEOUT_RESET;
      arm_limit  = ARMING_TIMEOUT_RESET;
      escalate   = 1'b0;
      expected_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          $display("%0t: result transfer with nothing predicted, expected none, got mode %0d",
                   $time, out_data.mode);
        end else begin
          want = expected_q.pop_front();
          check_field("mode", want.mode, out_data.mode);
          check_field("success", 3'(want.success), 3'(out_data.success));
          check_field("estop_latched", 3'(want.estop_latched), 3'(out_data.estop_latched));
          check_field("start_autopilot", 3'(want.start_autopilot),
                      3'(out_data.start_autopilot));
          check_field("stop_autopilot", 3'(want.stop_autopilot),
                      3'(out_data.stop_autopilot));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_HEARTBEAT_TIMEOUT: beat_limit = cfg_data;
          REG_ARMING_TIMEOUT:    arm_limit  = cfg_data;
          REG_ESCALATE:          escalate   = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_q.push_back(predict_event(in_data));
    end
    awaited = expected_q.size();
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// Top-level testbench of the vehicle mode supervisor: clock, reset, stimulus and verdict.
module tb;
  import vms_pkg::*;

  // A run is declared hung once this many cycles pass without any transfer.
  // The longest honest quiet stretch is the deliberate receiver hold-off.
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 80;
  localparam int PHASE_EVENTS = 280;

  logic        clk;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  vms_in_t     in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  vms_out_t    out_data;
  logic        cfg_we    = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

  int          mismatches;
  int          awaited;

  // Shared between the stimulus and the receiver: whether random idling is on,
  // and a count of requested receiver hold-offs.
  bit          gaps_on = 1'b1;
  int          hold_requests = 0;

  // Running event time and the timeouts currently programmed, used only to
  // aim the time steps at the interesting edges.
  logic [31:0] clock_ms = '0;
  logic [15:0] beat_limit_now = HEARTBEAT_TIMEOUT_RESET;
  logic [15:0] arm_limit_now  = ARMING_TIMEOUT_RESET;
  int          sent = 0;

  vehicle_mode_supervisor i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  vms_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .awaited    (awaited)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver side. A hold-off request keeps ready low for a fixed stretch so
  // that the output buffer fills and the block has to stall its input.
  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(gaps_on && $urandom_range(99) < 35);
      end
    end
  end

  // Watchdog: any transfer, a register write or reset restarts the count.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
        quiet = 0;
      else
        quiet++;
    end
    $display("Mismatches found");
    $finish;
  end

  // Offers one event and returns at the edge where it is transferred. Any
  // idle gap lowers valid first, so valid is never dropped and raised again
  // within the same time step.
  task automatic send_event(kind_t k, logic [31:0] stamp);
    if (gaps_on && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{kind: k, now_ms: stamp};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  // Time step aimed at a timeout: zero or a short step, exactly on it or one either
  // side, anywhere up to about twice it, or a random jump that may wrap the 32-bit clock.
  function automatic logic [31:0] pick_delta(logic [15:0] limit);
    case ($urandom_range(7))
      0:       return 32'd0;
      1:       return $urandom_range(1, 3);
      2, 3:    return {16'd0, limit} + $urandom_range(0, 2) - 1;
      4:       return {16'd0, limit};
      5:       return $urandom_range(0, 2 * limit + 2);
      6:       return $urandom;
      default: return $urandom_range(4, 60);
    endcase
  endfunction

  task automatic step_event(kind_t k, logic [15:0] limit);
    clock_ms = clock_ms + pick_delta(limit);
    send_event(k, clock_ms);
  endtask

  // Stops offering and waits until every predicted result has been seen.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Writes all three registers on consecutive edges; write enable is lowered
  // once at the end.
  task automatic apply_settings(logic [15:0] beat, logic [15:0] arm, logic esc);
    cfg_we    <= 1'b1;
    cfg_index <= REG_HEARTBEAT_TIMEOUT;
    cfg_data  <= beat;
    @(posedge clk);
    cfg_index <= REG_ARMING_TIMEOUT;
    cfg_data  <= arm;
    @(posedge clk);
    cfg_index <= REG_ESCALATE;
    cfg_data  <= {{(CFG_DATA_BITS-1){1'b0}}, esc};
    @(posedge clk);
    cfg_we <= 1'b0;
    beat_limit_now = beat;
    arm_limit_now  = arm;
  endtask

  // A well-formed flight: get to manual, arm, go to auto (or let arming
  // time out), a few heartbeats and status checks, then some way out.
  task automatic fly_sequence();
    int hops;
    if ($urandom_range(3) == 0) step_event(KIND_CLEAR_ESTOP, beat_limit_now);
    if ($urandom_range(1) == 0) step_event(KIND_REQ_MANUAL, beat_limit_now);
    else step_event(KIND_STATUS_TICK, beat_limit_now);
    step_event(KIND_REQ_AUTO, arm_limit_now);
    if ($urandom_range(3) == 0) step_event(KIND_STATUS_TICK, arm_limit_now);
    else step_event(KIND_READY, arm_limit_now);
    hops = $urandom_range(1, 6);
    repeat (hops) begin
      case ($urandom_range(5))
        0, 1:    step_event(KIND_HEARTBEAT, beat_limit_now);
        2:       step_event(KIND_REQ_AUTO, beat_limit_now);
        default: step_event(KIND_STATUS_TICK, beat_limit_now);
      endcase
    end
    case ($urandom_range(3))
      0:       step_event(KIND_OVERRIDE, beat_limit_now);
      1:       step_event(KIND_REQ_MANUAL, beat_limit_now);
      2:       step_event(KIND_REQ_ESTOP, beat_limit_now);
      default: step_event(KIND_STATUS_TICK, beat_limit_now);
    endcase
  endtask

  // Any kind at any time, now and then with an absolute jump of the clock.
  task automatic noise_event();
    if ($urandom_range(99) < 15) clock_ms = $urandom;
    if ($urandom_range(1) == 0) step_event(kind_t'($urandom_range(7)), beat_limit_now);
    else step_event(kind_t'($urandom_range(7)), arm_limit_now);
  endtask

  // One phase of random traffic under a fresh register setting.
  task automatic run_phase(logic [15:0] beat, logic [15:0] arm, logic esc, bit gaps,
                           bit hold);
    int target;
    settle();
    apply_settings(beat, arm, esc);
    gaps_on = gaps;
    if (hold) hold_requests++;
    target = sent + PHASE_EVENTS;
    while (sent < target) begin
      if ($urandom_range(99) < 75) fly_sequence();
      else noise_event();
    end
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part under the reset settings: 200 ms heartbeat, 5000 ms arming,
    // no escalation.
    send_event(KIND_HEARTBEAT,   32'd5);
    send_event(KIND_OVERRIDE,    32'd6);     // override outside auto is ignored
    send_event(KIND_READY,       32'd7);     // ready outside arming fails
    send_event(KIND_STATUS_TICK, 32'd8);     // init to manual
    send_event(KIND_STATUS_TICK, 32'd9);     // nothing happens in manual
    send_event(KIND_REQ_MANUAL,  32'd10);    // same mode fails
    send_event(KIND_REQ_AUTO,    32'd20);    // arming, start pulse
    send_event(KIND_STATUS_TICK, 32'd5020);  // exactly on the arming timeout: stays
    send_event(KIND_READY,       32'd5021);  // auto
    send_event(KIND_REQ_AUTO,    32'd5022);  // auto to arming: both pulses
    send_event(KIND_READY,       32'd5023);
    send_event(KIND_HEARTBEAT,   32'd5100);
    send_event(KIND_STATUS_TICK, 32'd5300);  // exactly on the heartbeat timeout
    send_event(KIND_STATUS_TICK, 32'd5301);  // stale heartbeat: back to manual
    send_event(KIND_REQ_ESTOP,   32'd5302);  // latch set
    send_event(KIND_REQ_ESTOP,   32'd5303);  // same mode: fails
    send_event(KIND_REQ_AUTO,    32'd5304);  // refused while latched
    send_event(KIND_READY,       32'd5305);
    send_event(KIND_STATUS_TICK, 32'd5306);  // nothing happens in estop
    send_event(KIND_REQ_MANUAL,  32'd5307);  // manual allowed, latch stays set
    send_event(KIND_CLEAR_ESTOP, 32'd5308);  // already manual: fails, latch cleared
    send_event(KIND_REQ_ESTOP,   32'd5309);
    send_event(KIND_CLEAR_ESTOP, 32'd5310);  // estop to manual
    send_event(KIND_REQ_AUTO,    32'hFFFF_FFF0);
    send_event(KIND_READY,       32'hFFFF_FFFF);
    send_event(KIND_STATUS_TICK, 32'h0000_0100); // heartbeat age taken across the wrap
    clock_ms = 32'h0000_0100;

    // Random phases. The third runs with no idling at all and carries the
    // long receiver hold-off while the sender keeps offering events.
    run_phase(16'd0, 16'd0, 1'b1, 1'b1, 1'b0);
    run_phase(16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 1'b0);
    run_phase(16'd20, 16'd35, 1'b1, 1'b0, 1'b1);
    run_phase(16'($urandom_range(1, 50)), 16'($urandom_range(1, 50)),
              1'($urandom_range(1)), 1'b1, 1'b0);
    run_phase(HEARTBEAT_TIMEOUT_RESET, ARMING_TIMEOUT_RESET, 1'b0, 1'b1, 1'b0);
    run_phase(16'($urandom_range(65535)), 16'($urandom_range(65535)),
              1'($urandom_range(1)), 1'b1, 1'b0);

    settle();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/vms_pkg.sv
rtl/vms_step.sv
rtl/vehicle_mode_supervisor.sv
sim/vms_checker.sv
sim/tb.sv
